// ===== rtl/q4q8_pkg.sv =====
`default_nettype none
package q4q8_pkg;

    localparam int COLUMNS         = 8;
    localparam int HALF_BLOCK_SIZE = 32;
    localparam int PACKS_PER_BLOCK = HALF_BLOCK_SIZE / 4;
    localparam int PACK_W          = $clog2(PACKS_PER_BLOCK);
    localparam int COL_W           = $clog2(COLUMNS);
    localparam int SUM_W           = 17;
    localparam int CFG_W           = 11;
    localparam logic [31:0] QNAN   = 32'h7FC0_0000;

    typedef struct packed {
        logic [31:0] act_low_quad;
        logic [31:0] act_high_quad;
        logic [63:0] weights_cols_0_1;
        logic [63:0] weights_cols_2_3;
        logic [63:0] weights_cols_4_5;
        logic [63:0] weights_cols_6_7;
        logic [15:0] col_scale_low;
        logic [15:0] col_scale_high;
        logic [15:0] act_scale_low;
        logic [15:0] act_scale_high;
    } t_in;

    typedef struct packed {
        logic [2:0]  column;
        logic [31:0] value;
        logic        last;
    } t_out;

    // one finished block pair, handed from the front to the back
    typedef struct packed {
        logic [COLUMNS-1:0][SUM_W-1:0] low_sum;
        logic [COLUMNS-1:0][SUM_W-1:0] high_sum;
        logic [COLUMNS-1:0][15:0]      wscale_low;
        logic [COLUMNS-1:0][15:0]      wscale_high;
        logic [15:0]                   ascale_low;
        logic [15:0]                   ascale_high;
        logic                          last;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE, B_SCALE, B_MUL, B_LZP, B_NORM, B_ALIGN,
        B_ADD, B_LZS, B_SHIFT, B_ROUND, B_EMIT
    } t_bstate;

endpackage
`default_nettype wire

// ===== rtl/q4q8_front.sv =====
`default_nettype none
module q4q8_front #(
    parameter int MAX_BLOCK_PAIRS = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  q4q8_pkg::t_in         i_data,
    input  wire                   i_cfg_we,
    input  wire [10:0]            i_cfg_data,
    input  wire                   i_q_full,
    output logic                  o_push,
    output q4q8_pkg::t_job        o_job
);
    import q4q8_pkg::*;

    localparam int BW = (MAX_BLOCK_PAIRS > 1) ? $clog2(MAX_BLOCK_PAIRS) : 1;
    localparam int CW = 14;

    logic [CFG_W-1:0]        r_bp;
    logic [PACK_W-1:0]       r_pack;
    logic [BW-1:0]           r_block;
    logic signed [SUM_W-1:0] r_low  [COLUMNS];
    logic signed [SUM_W-1:0] r_high [COLUMNS];
    logic [15:0]             r_wsl  [COLUMNS];
    logic [15:0]             r_wsh  [COLUMNS];

    logic [3:0][63:0]        w_field;
    logic [31:0]             w_word [COLUMNS];
    logic signed [13:0]      w_al [4];
    logic signed [13:0]      w_ah [4];
    logic signed [13:0]      w_dl [COLUMNS];
    logic signed [13:0]      w_dh [COLUMNS];
    logic signed [SUM_W-1:0] n_low  [COLUMNS];
    logic signed [SUM_W-1:0] n_high [COLUMNS];
    logic [CW-1:0]           w_eff;
    logic                    w_accept;
    logic                    w_end_pack;
    logic                    w_last;

    assign w_field = {i_data.weights_cols_6_7, i_data.weights_cols_4_5,
                      i_data.weights_cols_2_3, i_data.weights_cols_0_1};

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_al[b] = 14'($signed(i_data.act_low_quad[8*b +: 8]));
            w_ah[b] = 14'($signed(i_data.act_high_quad[8*b +: 8]));
        end
        for (int c = 0; c < COLUMNS; c++) begin
            w_word[c] = w_field[c/2][(c%2)*32 +: 32];
            w_dl[c] = '0;
            w_dh[c] = '0;
            // code minus 8 is the nibble with its top bit flipped
            for (int b = 0; b < 4; b++) begin
                w_dl[c] = w_dl[c] + w_al[b] * 14'($signed(
                          {~w_word[c][8*b+3], w_word[c][8*b +: 3]}));
                w_dh[c] = w_dh[c] + w_ah[b] * 14'($signed(
                          {~w_word[c][8*b+7], w_word[c][8*b+4 +: 3]}));
            end
            n_low[c]  = r_low[c] + SUM_W'(w_dl[c]);
            n_high[c] = r_high[c] + SUM_W'(w_dh[c]);
        end
    end

    assign w_end_pack = (r_pack == PACK_W'(PACKS_PER_BLOCK - 1));
    assign o_stall    = w_end_pack && i_q_full;
    assign w_accept   = i_valid && !o_stall;
    assign o_push     = w_accept && w_end_pack;

    always_comb begin
        priority if (r_bp == '0)
            w_eff = CW'(1);
        else if (CW'(r_bp) > CW'(MAX_BLOCK_PAIRS))
            w_eff = CW'(MAX_BLOCK_PAIRS);
        else
            w_eff = CW'(r_bp);
    end
    assign w_last = (CW'(r_block) + CW'(1)) >= w_eff;

    always_comb begin
        for (int c = 0; c < COLUMNS; c++) begin
            o_job.low_sum[c]  = n_low[c];
            o_job.high_sum[c] = n_high[c];
            o_job.wscale_low[c]  = (c == COLUMNS - 1) ? i_data.col_scale_low  : r_wsl[c];
            o_job.wscale_high[c] = (c == COLUMNS - 1) ? i_data.col_scale_high : r_wsh[c];
        end
        o_job.ascale_low  = i_data.act_scale_low;
        o_job.ascale_high = i_data.act_scale_high;
        o_job.last        = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp    <= CFG_W'(1);
            r_pack  <= '0;
            r_block <= '0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_low[c]  <= '0;
                r_high[c] <= '0;
            end
        end else begin
            if (i_cfg_we)
                r_bp <= i_cfg_data;
            if (w_accept) begin
                if (w_end_pack) begin
                    r_pack <= '0;
                    r_block <= w_last ? '0 : r_block + BW'(1);
                    for (int c = 0; c < COLUMNS; c++) begin
                        r_low[c]  <= '0;
                        r_high[c] <= '0;
                    end
                end else begin
                    r_pack <= r_pack + PACK_W'(1);
                    for (int c = 0; c < COLUMNS; c++) begin
                        r_low[c]  <= n_low[c];
                        r_high[c] <= n_high[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wsl[r_pack] <= i_data.col_scale_low;
            r_wsh[r_pack] <= i_data.col_scale_high;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/q4q8_queue.sv =====
`default_nettype none
module q4q8_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  q4q8_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output q4q8_pkg::t_job  o_job
);
    import q4q8_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= ~r_wp;
            if (i_pop)
                r_rp <= ~r_rp;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

// ===== rtl/q4q8_back.sv =====
`default_nettype none
module q4q8_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  q4q8_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire             i_stall,
    output q4q8_pkg::t_out  o_data
);
    import q4q8_pkg::*;

    localparam logic signed [10:0] SENT = -11'sd400;

    function automatic logic [6:0] lead_pos(input logic [78:0] v);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < 79; i++)
            if (v[i])
                p = 7'(i);
        return p;
    endfunction

    t_bstate             r_state, n_state;
    logic [COL_W-1:0]    r_col;
    logic                r_half;
    logic [31:0]         r_sum [COLUMNS];
    logic                r_ovalid;
    t_out                r_out;

    // scale and product
    logic [21:0]         r_ms;
    logic [5:0]          r_es;
    logic                r_snan, r_sinf, r_ssign;
    logic                r_nneg;
    logic [15:0]         r_nmag;
    logic [37:0]         r_mp;
    logic [5:0]          r_lzp;
    logic                r_pzero;
    // operands
    logic [37:0]         r_pm, r_am;
    logic signed [10:0]  r_pe, r_ae;
    logic                r_ps, r_as;
    logic                r_xnan, r_xinf, r_xsign;
    // sum
    logic [78:0]         r_big, r_small;
    logic                r_bs, r_sm_s;
    logic signed [10:0]  r_ebig;
    logic [78:0]         r_add;
    logic                r_rs;
    logic                r_zsign;
    logic [6:0]          r_lz2;
    logic                r_zero;
    logic [78:0]         r_nm;
    logic signed [10:0]  r_re;

    // combinational helpers
    logic signed [SUM_W-1:0] w_n;
    logic signed [SUM_W-1:0] w_nabs;
    logic [15:0]         w_asc, w_wsc;
    logic [10:0]         w_siga, w_sigw;
    logic [4:0]          w_epa, w_epw;
    logic                w_nana, w_nanw, w_infa, w_infw, w_zeroa, w_zerow;
    logic [31:0]         w_acc;
    logic                w_pnan, w_pinf, w_anan, w_ainf, w_psign;
    logic                w_pbig;
    logic [10:0]         w_d;
    logic [77:0]         w_sfull, w_sshift;
    logic                w_sticky;
    logic [23:0]         w_mant;
    logic [24:0]         w_m25;
    logic signed [10:0]  w_bexp;
    logic [31:0]         w_res;
    logic                w_slot;
    logic                w_emit;
    logic                w_write;

    assign w_n   = $signed(r_half ? i_job.high_sum[r_col] : i_job.low_sum[r_col]);
    assign w_nabs = w_n[SUM_W-1] ? -w_n : w_n;
    assign w_asc = r_half ? i_job.ascale_high : i_job.ascale_low;
    assign w_wsc = r_half ? i_job.wscale_high[r_col] : i_job.wscale_low[r_col];

    assign w_siga  = {|w_asc[14:10], w_asc[9:0]};
    assign w_sigw  = {|w_wsc[14:10], w_wsc[9:0]};
    assign w_epa   = (w_asc[14:10] == '0) ? 5'd1 : w_asc[14:10];
    assign w_epw   = (w_wsc[14:10] == '0) ? 5'd1 : w_wsc[14:10];
    assign w_nana  = (&w_asc[14:10]) && (|w_asc[9:0]);
    assign w_nanw  = (&w_wsc[14:10]) && (|w_wsc[9:0]);
    assign w_infa  = (&w_asc[14:10]) && !(|w_asc[9:0]);
    assign w_infw  = (&w_wsc[14:10]) && !(|w_wsc[9:0]);
    assign w_zeroa = !(|w_asc[14:0]);
    assign w_zerow = !(|w_wsc[14:0]);

    assign w_acc   = r_sum[r_col];
    assign w_pnan  = r_snan || (r_sinf && r_nmag == '0);
    assign w_pinf  = r_sinf && !w_pnan;
    assign w_psign = r_nneg ^ r_ssign;
    assign w_anan  = (&w_acc[30:23]) && (|w_acc[22:0]);
    assign w_ainf  = (&w_acc[30:23]) && !(|w_acc[22:0]);

    // alignment: larger operand stays, smaller one shifts right with sticky
    assign w_pbig  = (r_pe > r_ae) || (r_pe == r_ae && r_pm >= r_am);
    assign w_d     = w_pbig ? 11'(r_pe - r_ae) : 11'(r_ae - r_pe);
    assign w_sfull = {(w_pbig ? r_am : r_pm), 40'b0};
    always_comb begin
        if (w_d >= 11'd78) begin
            w_sshift = '0;
            w_sticky = |w_sfull;
        end else begin
            w_sshift = w_sfull >> w_d[6:0];
            w_sticky = |(w_sfull & ~({78{1'b1}} << w_d[6:0]));
        end
    end

    // round to nearest even
    always_comb begin
        w_mant = r_nm[78:55];
        w_m25  = {1'b0, w_mant} + 25'(r_nm[54] && ((|r_nm[53:0]) || w_mant[0]));
        w_bexp = r_re + 11'sd127 + (w_m25[24] ? 11'sd1 : 11'sd0);
        priority if (r_xnan)
            w_res = QNAN;
        else if (r_xinf)
            w_res = {r_xsign, 8'hFF, 23'b0};
        else if (r_zero)
            w_res = {r_zsign, 31'b0};
        else if (w_bexp >= 11'sd255)
            w_res = {r_rs, 8'hFF, 23'b0};
        else
            w_res = {r_rs, w_bexp[7:0], (w_m25[24] ? w_m25[23:1] : w_m25[22:0])};
    end

    assign w_slot  = !r_ovalid || !i_stall;
    assign w_emit  = (r_state == B_EMIT) && w_slot;
    assign w_write = (r_state == B_ROUND);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_IDLE:  if (!i_empty) n_state = B_SCALE;
            B_SCALE: n_state = B_MUL;
            B_MUL:   n_state = B_LZP;
            B_LZP:   n_state = B_NORM;
            B_NORM:  n_state = B_ALIGN;
            B_ALIGN: n_state = B_ADD;
            B_ADD:   n_state = B_LZS;
            B_LZS:   n_state = B_SHIFT;
            B_SHIFT: n_state = B_ROUND;
            B_ROUND: begin
                priority if (!r_half)
                    n_state = B_SCALE;
                else if (r_col != COL_W'(COLUMNS - 1))
                    n_state = B_SCALE;
                else if (i_job.last)
                    n_state = B_EMIT;
                else begin
                    n_state = B_IDLE;
                    o_pop   = 1'b1;
                end
            end
            B_EMIT: begin
                if (w_slot && r_col == COL_W'(COLUMNS - 1)) begin
                    n_state = B_IDLE;
                    o_pop   = 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_col    <= '0;
            r_half   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < COLUMNS; c++)
                r_sum[c] <= '0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                r_sum[r_col] <= w_res;
                r_half <= ~r_half;
                if (r_half)
                    r_col <= r_col + COL_W'(1);
            end
            if (w_emit) begin
                r_sum[r_col] <= '0;
                r_col <= r_col + COL_W'(1);
            end
            if (w_emit)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.column <= 3'(r_col);
            r_out.value  <= w_acc;
            r_out.last   <= (r_col == COL_W'(COLUMNS - 1));
        end
        unique case (r_state)
            B_SCALE: begin
                r_ms    <= {11'b0, w_siga} * {11'b0, w_sigw};
                r_es    <= 6'(w_epa) + 6'(w_epw);
                r_snan  <= w_nana || w_nanw || (w_infa && w_zerow) || (w_infw && w_zeroa);
                r_sinf  <= w_infa || w_infw;
                r_ssign <= w_asc[15] ^ w_wsc[15];
                r_nneg  <= w_n[SUM_W-1];
                r_nmag  <= w_nabs[15:0];
            end
            B_MUL: r_mp <= {22'b0, r_nmag} * {16'b0, r_ms};
            B_LZP: begin
                r_lzp   <= 6'(lead_pos({41'b0, r_mp}));
                r_pzero <= (r_mp == '0);
            end
            B_NORM: begin
                r_pm <= r_mp << (6'd37 - r_lzp);
                r_pe <= r_pzero ? SENT
                        : $signed({5'b0, r_es}) - 11'sd50 + $signed({5'b0, r_lzp});
                r_ps <= w_psign;
                r_am <= {(|w_acc[30:23]), w_acc[22:0], 14'b0};
                r_ae <= (w_acc[30:23] == '0) ? SENT : $signed({3'b0, w_acc[30:23]}) - 11'sd127;
                r_as <= w_acc[31];
                r_xnan  <= w_pnan || w_anan || (w_pinf && w_ainf && (w_psign != w_acc[31]));
                r_xinf  <= w_pinf || w_ainf;
                r_xsign <= w_pinf ? w_psign : w_acc[31];
            end
            B_ALIGN: begin
                r_big   <= {1'b0, (w_pbig ? r_pm : r_am), 40'b0};
                r_small <= {1'b0, w_sshift[77:1], w_sshift[0] | w_sticky};
                r_bs    <= w_pbig ? r_ps : r_as;
                r_sm_s  <= w_pbig ? r_as : r_ps;
                r_ebig  <= w_pbig ? r_pe : r_ae;
                r_zsign <= r_ps && r_as;
            end
            B_ADD: begin
                r_add <= (r_bs == r_sm_s) ? r_big + r_small : r_big - r_small;
                r_rs  <= r_bs;
            end
            B_LZS: begin
                r_lz2  <= lead_pos(r_add);
                r_zero <= (r_add == '0);
            end
            B_SHIFT: begin
                r_nm <= r_add << (7'd78 - r_lz2);
                r_re <= r_ebig + $signed({4'b0, r_lz2}) - 11'sd77;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/q4_q8_block_dot_product.sv =====
`default_nettype none
// q4 x q8 block dot product, one activation row against eight weight columns
// input channel: i_valid / o_stall / i_data, one beat per pack of four
//   elements per half; eight beats make one 64-element block pair
// output channel: o_valid / i_stall / o_data, eight beats (columns 0..7)
//   after the last block pair of a row, last set on column 7
// config: i_cfg_we / i_cfg_data write the block pair count (0 acts as 1,
//   counts above MAX_BLOCK_PAIRS saturate); write only while idle
// packs are taken one per cycle while o_stall is low; integer sums are
//   formed as the beat arrives; the eighth pack hands the block pair through
//   a two-entry queue to the float unit, which runs 16 fused multiply-adds
//   (one per column and half), each through the scale, multiply, leading
//   zero, normalise, align, add, leading zero, shift and round states; once
//   the queue fills, the eighth pack is held by o_stall until an entry frees
// after the last block pair of a row, results come out one per cycle
//   while the receiver takes them
// reset: synchronous, clears the sums, counters and queue; count returns to 1
// a stalled output holds its beat; the float unit waits for a free slot
module q4_q8_block_dot_product #(
    parameter int MAX_BLOCK_PAIRS = 1024
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  q4q8_pkg::t_in   i_data,
    output logic            o_valid,
    input  wire             i_stall,
    output q4q8_pkg::t_out  o_data,
    input  wire             i_cfg_we,
    input  wire [10:0]      i_cfg_data
);
    import q4q8_pkg::*;

    t_job w_push_job, w_head_job;
    logic w_push, w_full, w_pop, w_empty;

    q4q8_front #(.MAX_BLOCK_PAIRS(MAX_BLOCK_PAIRS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    q4q8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    q4q8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// ===== rtl/q4q8_checker.sv =====
`default_nettype none
module q4q8_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_valid,
    input wire             i_stall,
    input q4q8_pkg::t_out  o_data
);
    import q4q8_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    // last marks column 7 and nothing else
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.column == 3'd7)))
        else $error("last flag does not match column");

    // columns come out in order within a row
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && !i_stall && !o_data.last)
        |-> o_valid && o_data.column == $past(o_data.column) + 3'd1)
        else $error("column sequence broken");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind q4_q8_block_dot_product q4q8_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire
